/* hw/rtl/ugl_pkg.sv */
`default_nettype none

package ugl_pkg;

    localparam int LANES     = 4;
    localparam int CQ_DEPTH  = 2;
    localparam int OQ_DEPTH  = 2;
    localparam int TIME_BITS = 32;

    // register index as seen in paddr[2]
    localparam logic REG_GRID_STEP = 1'b0;

    typedef enum logic
    {
        CMD_PASS,
        CMD_RUN
    } cmd_kind_t;

    typedef struct packed
    {
        cmd_kind_t             kind;
        logic [TIME_BITS-1:0]  origin;
        logic [TIME_BITS-1:0]  prev;
        logic [TIME_BITS-1:0]  cur;
    } cmd_ctl_t;

    typedef enum logic [3:0]
    {
        BK_IDLE,
        BK_LO_GO,
        BK_LO_WAIT,
        BK_HI_GO,
        BK_HI_WAIT,
        BK_PLAN,
        BK_MUL,
        BK_FRAC_GO,
        BK_FRAC_WAIT,
        BK_EMIT
    } back_state_t;

endpackage

`default_nettype wire

/* hw/rtl/ugl_front.sv */
`default_nettype none

module ugl_front
    import ugl_pkg::*;
#(
    parameter int VALUE_BITS = 24,
    parameter int CHANNELS   = 4
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [TIME_BITS-1:0]                 sample_time,
    input  logic [LANES-1:0][VALUE_BITS-1:0]     values,
    input  logic                                 cmd_pop,
    output logic                                 cmd_valid,
    output cmd_ctl_t                             cmd_ctl,
    output logic [LANES-1:0][VALUE_BITS-1:0]     cmd_pv,
    output logic [LANES-1:0][VALUE_BITS-1:0]     cmd_cv
);

    localparam int PW = $clog2(CQ_DEPTH);
    localparam int CW = $clog2(CQ_DEPTH + 1);

    logic                               started_reg, started_next;
    logic [TIME_BITS-1:0]               origin_reg, origin_next;
    logic [TIME_BITS-1:0]               prev_time_reg, prev_time_next;
    logic [LANES-1:0][VALUE_BITS-1:0]   prev_vals_reg, prev_vals_next;

    cmd_ctl_t                           ctl_q_reg [CQ_DEPTH];
    logic [LANES-1:0][VALUE_BITS-1:0]   pv_q_reg  [CQ_DEPTH];
    logic [LANES-1:0][VALUE_BITS-1:0]   cv_q_reg  [CQ_DEPTH];
    logic [PW-1:0]                      wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]                      cnt_reg, cnt_next;

    logic                               accept;
    logic                               enq;
    logic                               deq;
    cmd_ctl_t                           enq_ctl;
    logic [LANES-1:0][VALUE_BITS-1:0]   cur_vals;

    assign full      = (cnt_reg == CW'(CQ_DEPTH));
    assign accept    = push && !full;
    assign cmd_valid = (cnt_reg != '0);
    assign deq       = cmd_pop && cmd_valid;
    assign cmd_ctl   = ctl_q_reg[rd_ptr_reg];
    assign cmd_pv    = pv_q_reg[rd_ptr_reg];
    assign cmd_cv    = cv_q_reg[rd_ptr_reg];

    // unused channels read as zero
    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            cur_vals[k] = (k < CHANNELS) ? values[k] : '0;
        end
    end

    // classify the row and keep the stream state
    always_comb
    begin
        started_next   = started_reg;
        origin_next    = origin_reg;
        prev_time_next = prev_time_reg;
        prev_vals_next = prev_vals_reg;
        enq            = 1'b0;
        enq_ctl.kind   = CMD_RUN;
        enq_ctl.origin = origin_reg;
        enq_ctl.prev   = prev_time_reg;
        enq_ctl.cur    = sample_time;
        if (accept)
        begin
            priority if (!started_reg)
            begin
                started_next   = 1'b1;
                origin_next    = sample_time;
                prev_time_next = sample_time;
                prev_vals_next = cur_vals;
                enq            = 1'b1;
                enq_ctl.kind   = CMD_PASS;
                enq_ctl.origin = sample_time;
                enq_ctl.prev   = sample_time;
            end
            else if (sample_time < prev_time_reg)
            begin
                enq = 1'b0;
            end
            else if (sample_time == prev_time_reg)
            begin
                prev_vals_next = cur_vals;
            end
            else
            begin
                prev_time_next = sample_time;
                prev_vals_next = cur_vals;
                enq            = 1'b1;
            end
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (enq && !deq)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (!enq && deq)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            origin_reg    <= '0;
            prev_time_reg <= '0;
            prev_vals_reg <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            started_reg   <= started_next;
            origin_reg    <= origin_next;
            prev_time_reg <= prev_time_next;
            prev_vals_reg <= prev_vals_next;
            cnt_reg       <= cnt_next;
            if (enq)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (deq)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            ctl_q_reg[wr_ptr_reg] <= enq_ctl;
            pv_q_reg[wr_ptr_reg]  <= prev_vals_reg;
            cv_q_reg[wr_ptr_reg]  <= cur_vals;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ugl_div.sv */
`default_nettype none

module ugl_div
    import ugl_pkg::*;
#(
    parameter int VALUE_BITS = 24
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            frac_mode,
    input  logic [VALUE_BITS+TIME_BITS-1:0] num,
    input  logic [TIME_BITS-1:0]            den,
    output logic [TIME_BITS-1:0]            quo,
    output logic [TIME_BITS-1:0]            rem,
    output logic                            done
);

    localparam int NW = VALUE_BITS + TIME_BITS;

    logic [TIME_BITS-1:0] rem_reg;
    logic [TIME_BITS-1:0] quo_reg;
    logic [TIME_BITS-1:0] den_reg;
    logic [5:0]           cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [TIME_BITS:0]   rem_sh;
    logic [TIME_BITS+1:0] diff;
    logic                 ge;
    logic [TIME_BITS-1:0] low_part;

    assign rem_sh   = {rem_reg, quo_reg[TIME_BITS-1]};
    assign diff     = {1'b0, rem_sh} - {2'b00, den_reg};
    assign ge       = !diff[TIME_BITS+1];
    assign low_part = TIME_BITS'(num[VALUE_BITS-1:0]) << (TIME_BITS - VALUE_BITS);

    assign quo  = quo_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= frac_mode ? 6'(VALUE_BITS) : 6'(TIME_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            if (frac_mode)
            begin
                rem_reg <= num[NW-1:VALUE_BITS];
                quo_reg <= low_part;
            end
            else
            begin
                rem_reg <= '0;
                quo_reg <= num[TIME_BITS-1:0];
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
            quo_reg <= {quo_reg[TIME_BITS-2:0], ge};
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ugl_back.sv */
`default_nettype none

module ugl_back
    import ugl_pkg::*;
#(
    parameter int VALUE_BITS = 24,
    parameter int CHANNELS   = 4,
    parameter int MAX_RUN    = 64
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [TIME_BITS-1:0]                 grid_step,
    input  logic                                 cmd_valid,
    output logic                                 cmd_pop,
    input  cmd_ctl_t                             cmd_ctl,
    input  logic [LANES-1:0][VALUE_BITS-1:0]     cmd_pv,
    input  logic [LANES-1:0][VALUE_BITS-1:0]     cmd_cv,
    input  logic                                 pop,
    output logic                                 empty,
    output logic [TIME_BITS-1:0]                 grid_time,
    output logic [LANES-1:0][VALUE_BITS-1:0]     out_vals,
    output logic                                 last_of_run,
    output logic                                 run_truncated
);

    localparam int NW = $clog2(MAX_RUN + 1);
    localparam int PB = VALUE_BITS + TIME_BITS;
    localparam int PW = $clog2(OQ_DEPTH);
    localparam int CW = $clog2(OQ_DEPTH + 1);

    back_state_t                        state_reg, state_next;
    cmd_ctl_t                           ctl_reg;
    logic [LANES-1:0][VALUE_BITS-1:0]   pv_reg, cv_reg;
    logic [TIME_BITS-1:0]               i1_reg, rem1_reg, total_reg, dt_reg;
    logic [NW-1:0]                      n_reg, idx_reg;
    logic                               trunc_reg;
    logic [TIME_BITS:0]                 dx_reg;
    logic [LANES-1:0][VALUE_BITS-1:0]   a_reg;
    logic [LANES-1:0]                   neg_reg;
    logic [LANES-1:0][PB-1:0]           prod_reg;

    logic [TIME_BITS-1:0]               step_eff;
    logic [TIME_BITS-1:0]               idx_num;
    logic                               div_start, div_frac;
    logic [TIME_BITS-1:0]               div_den;
    logic [LANES-1:0][TIME_BITS-1:0]    div_quo;
    logic [TIME_BITS-1:0]               div_rem;
    logic                               div_done;
    logic                               is_last;

    // result queue
    logic [TIME_BITS-1:0]               oq_time_reg  [OQ_DEPTH];
    logic [LANES-1:0][VALUE_BITS-1:0]   oq_vals_reg  [OQ_DEPTH];
    logic                               oq_last_reg  [OQ_DEPTH];
    logic                               oq_trunc_reg [OQ_DEPTH];
    logic [PW-1:0]                      oq_wr_reg, oq_rd_reg;
    logic [CW-1:0]                      oq_cnt_reg;
    logic                               oq_full, oq_push, oq_pop;
    logic [TIME_BITS-1:0]               em_time;
    logic [LANES-1:0][VALUE_BITS-1:0]   em_vals;
    logic                               em_last, em_trunc;

    assign step_eff  = (grid_step == '0) ? TIME_BITS'(1) : grid_step;
    assign idx_num   = (state_reg == BK_LO_GO) ? (ctl_reg.prev - ctl_reg.origin)
                                               : (ctl_reg.cur - ctl_reg.origin);
    assign div_start = (state_reg == BK_LO_GO) || (state_reg == BK_HI_GO)
                       || (state_reg == BK_FRAC_GO);
    assign div_frac  = (state_reg == BK_FRAC_GO);
    assign div_den   = div_frac ? dt_reg : step_eff;
    assign is_last   = (idx_reg == n_reg - NW'(1));

    genvar k;
    generate
        for (k = 0; k < LANES; k++)
        begin : g_lane
            if (k == 0)
            begin : g_first
                ugl_div #(.VALUE_BITS(VALUE_BITS)) u_div
                (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .start     (div_start),
                    .frac_mode (div_frac),
                    .num       (div_frac ? prod_reg[k] : PB'(idx_num)),
                    .den       (div_den),
                    .quo       (div_quo[k]),
                    .rem       (div_rem),
                    .done      (div_done)
                );
            end
            else if (k < CHANNELS)
            begin : g_more
                ugl_div #(.VALUE_BITS(VALUE_BITS)) u_div
                (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .start     (div_frac),
                    .frac_mode (div_frac),
                    .num       (prod_reg[k]),
                    .den       (div_den),
                    .quo       (div_quo[k]),
                    .rem       (),
                    .done      ()
                );
            end
            else
            begin : g_off
                assign div_quo[k] = '0;
            end
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    state_next = (cmd_ctl.kind == CMD_PASS) ? BK_EMIT : BK_LO_GO;
                end
            end
            BK_LO_GO:     state_next = BK_LO_WAIT;
            BK_LO_WAIT:   state_next = div_done ? BK_HI_GO : BK_LO_WAIT;
            BK_HI_GO:     state_next = BK_HI_WAIT;
            BK_HI_WAIT:   state_next = div_done ? BK_PLAN : BK_HI_WAIT;
            BK_PLAN:      state_next = (total_reg == '0) ? BK_IDLE : BK_MUL;
            BK_MUL:       state_next = BK_FRAC_GO;
            BK_FRAC_GO:   state_next = BK_FRAC_WAIT;
            BK_FRAC_WAIT: state_next = div_done ? BK_EMIT : BK_FRAC_WAIT;
            BK_EMIT:
            begin
                if (!oq_full)
                begin
                    state_next = (ctl_reg.kind == CMD_PASS || is_last) ? BK_IDLE : BK_MUL;
                end
            end
            default:      state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // run datapath
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            ctl_reg <= cmd_ctl;
            pv_reg  <= cmd_pv;
            cv_reg  <= cmd_cv;
        end
        if (state_reg == BK_LO_WAIT && div_done)
        begin
            i1_reg   <= div_quo[0];
            rem1_reg <= div_rem;
        end
        if (state_reg == BK_HI_WAIT && div_done)
        begin
            total_reg <= div_quo[0] - i1_reg;
        end
        if (state_reg == BK_PLAN)
        begin
            trunc_reg <= (total_reg > TIME_BITS'(MAX_RUN));
            n_reg     <= (total_reg > TIME_BITS'(MAX_RUN)) ? NW'(MAX_RUN)
                                                           : total_reg[NW-1:0];
            idx_reg   <= '0;
            dx_reg    <= {1'b0, step_eff} - {1'b0, rem1_reg};
            dt_reg    <= ctl_reg.cur - ctl_reg.prev;
            for (int c = 0; c < LANES; c++)
            begin
                logic [VALUE_BITS:0] d;
                logic [VALUE_BITS:0] mag;
                d          = {cv_reg[c][VALUE_BITS-1], cv_reg[c]}
                             - {pv_reg[c][VALUE_BITS-1], pv_reg[c]};
                mag        = d[VALUE_BITS] ? (~d + (VALUE_BITS+1)'(1)) : d;
                neg_reg[c] <= d[VALUE_BITS];
                a_reg[c]   <= mag[VALUE_BITS-1:0];
            end
        end
        if (state_reg == BK_MUL)
        begin
            for (int c = 0; c < LANES; c++)
            begin
                prod_reg[c] <= PB'(a_reg[c]) * PB'(dx_reg[TIME_BITS-1:0]);
            end
        end
        if (state_reg == BK_EMIT && !oq_full)
        begin
            idx_reg <= idx_reg + NW'(1);
            dx_reg  <= dx_reg + {1'b0, step_eff};
        end
    end

    // one grid point, or the origin row passed through
    always_comb
    begin
        if (ctl_reg.kind == CMD_PASS)
        begin
            em_time  = ctl_reg.cur;
            em_vals  = cv_reg;
            em_last  = 1'b1;
            em_trunc = 1'b0;
        end
        else
        begin
            em_time  = ctl_reg.prev + dx_reg[TIME_BITS-1:0];
            em_last  = is_last;
            em_trunc = trunc_reg;
            for (int c = 0; c < LANES; c++)
            begin
                if (c < CHANNELS)
                begin
                    em_vals[c] = neg_reg[c] ? (pv_reg[c] - div_quo[c][VALUE_BITS-1:0])
                                            : (pv_reg[c] + div_quo[c][VALUE_BITS-1:0]);
                end
                else
                begin
                    em_vals[c] = '0;
                end
            end
        end
    end

    assign oq_full  = (oq_cnt_reg == CW'(OQ_DEPTH));
    assign empty    = (oq_cnt_reg == '0);
    assign oq_push  = (state_reg == BK_EMIT) && !oq_full;
    assign oq_pop   = pop && !empty;

    assign grid_time     = oq_time_reg[oq_rd_reg];
    assign out_vals      = oq_vals_reg[oq_rd_reg];
    assign last_of_run   = oq_last_reg[oq_rd_reg];
    assign run_truncated = oq_trunc_reg[oq_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (oq_push)
            begin
                oq_wr_reg <= oq_wr_reg + PW'(1);
            end
            if (oq_pop)
            begin
                oq_rd_reg <= oq_rd_reg + PW'(1);
            end
            if (oq_push && !oq_pop)
            begin
                oq_cnt_reg <= oq_cnt_reg + CW'(1);
            end
            else if (!oq_push && oq_pop)
            begin
                oq_cnt_reg <= oq_cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_time_reg[oq_wr_reg]  <= em_time;
            oq_vals_reg[oq_wr_reg]  <= em_vals;
            oq_last_reg[oq_wr_reg]  <= em_last;
            oq_trunc_reg[oq_wr_reg] <= em_trunc;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/uniform_grid_linear_resampler.sv */
// uniform grid linear resampler
//
// input channel: queue style, a row (sample_time, value_0..3) transfers when
// push is high and full is low. rows are classified on entry: the first row
// after reset sets the time origin, a row with an older time is dropped, a
// row with an equal time only replaces the held values, a later row queues a
// run of grid points. a two-entry command queue sits between the front and
// the interpolation engine, so rows keep flowing while a run is worked off.
// result channel: queue style, the oldest grid point is shown while empty is
// low and transfers when pop is high; a two-entry result queue holds points
// while the receiver stalls, and the engine waits when it is full.
// timing: the origin row is passed straight through to the result queue. a run
// first finds its grid indexes with two divisions on the 32-step shared divider,
// then each grid point takes a multiply state and a VALUE_BITS-step divider per
// channel, all channels in parallel.
// reset: grid_step returns to 1, the origin is forgotten, both queues empty.
// grid_step is written over apb at byte address 0; a zero step acts as 1.
`default_nettype none

module uniform_grid_linear_resampler
    import ugl_pkg::*;
#(
    parameter int CHANNELS   = 4,
    parameter int MAX_RUN    = 64,
    parameter int VALUE_BITS = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // sample rows
    input  logic                          push,
    output logic                          full,
    input  logic [TIME_BITS-1:0]          sample_time,
    input  logic signed [VALUE_BITS-1:0]  value_0,
    input  logic signed [VALUE_BITS-1:0]  value_1,
    input  logic signed [VALUE_BITS-1:0]  value_2,
    input  logic signed [VALUE_BITS-1:0]  value_3,
    // grid points
    output logic                          empty,
    input  logic                          pop,
    output logic [TIME_BITS-1:0]          grid_time,
    output logic signed [VALUE_BITS-1:0]  out_value_0,
    output logic signed [VALUE_BITS-1:0]  out_value_1,
    output logic signed [VALUE_BITS-1:0]  out_value_2,
    output logic signed [VALUE_BITS-1:0]  out_value_3,
    output logic                          last_of_run,
    output logic                          run_truncated
);

    logic [31:0]                        grid_step_reg;
    logic                               cfg_wr;

    logic [LANES-1:0][VALUE_BITS-1:0]   in_vals;
    logic [LANES-1:0][VALUE_BITS-1:0]   out_vals;

    logic                               cmd_valid;
    logic                               cmd_pop;
    cmd_ctl_t                           cmd_ctl;
    logic [LANES-1:0][VALUE_BITS-1:0]   cmd_pv;
    logic [LANES-1:0][VALUE_BITS-1:0]   cmd_cv;

    // apb register file, zero wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_GRID_STEP);
    assign prdata = (paddr[2] == REG_GRID_STEP) ? grid_step_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_step_reg <= 32'd1;
        end
        else if (cfg_wr)
        begin
            grid_step_reg <= pwdata;
        end
    end

    assign in_vals[0] = value_0;
    assign in_vals[1] = value_1;
    assign in_vals[2] = value_2;
    assign in_vals[3] = value_3;

    assign out_value_0 = out_vals[0];
    assign out_value_1 = out_vals[1];
    assign out_value_2 = out_vals[2];
    assign out_value_3 = out_vals[3];

    // front: accepts rows, tracks origin and previous row, queues commands
    ugl_front #(.VALUE_BITS(VALUE_BITS), .CHANNELS(CHANNELS)) u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .sample_time (sample_time),
        .values      (in_vals),
        .cmd_pop     (cmd_pop),
        .cmd_valid   (cmd_valid),
        .cmd_ctl     (cmd_ctl),
        .cmd_pv      (cmd_pv),
        .cmd_cv      (cmd_cv)
    );

    // back: index division, per-point multiply and divide, result queue
    ugl_back #(.VALUE_BITS(VALUE_BITS), .CHANNELS(CHANNELS), .MAX_RUN(MAX_RUN)) u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .grid_step     (grid_step_reg),
        .cmd_valid     (cmd_valid),
        .cmd_pop       (cmd_pop),
        .cmd_ctl       (cmd_ctl),
        .cmd_pv        (cmd_pv),
        .cmd_cv        (cmd_cv),
        .pop           (pop),
        .empty         (empty),
        .grid_time     (grid_time),
        .out_vals      (out_vals),
        .last_of_run   (last_of_run),
        .run_truncated (run_truncated)
    );

endmodule

`default_nettype wire

/* hw/rtl/ugl_checker.sv */
`default_nettype none

module ugl_checker
#(
    parameter int VALUE_BITS = 24
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [2:0]                    paddr,
    input logic [31:0]                   pwdata,
    input logic [31:0]                   prdata,
    input logic                          pready,
    input logic                          empty,
    input logic                          pop,
    input logic [31:0]                   grid_time,
    input logic signed [VALUE_BITS-1:0]  out_value_0
);

    // both queues are cleared by reset; the result queue is checked empty in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result queue not empty in reset");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    // a written step reads back on the next cycle
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr == 3'd0)
        |=> (paddr != 3'd0 || prdata == $past(pwdata)))
        else $error("grid_step readback mismatch");

    // a stalled result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(grid_time) && $stable(out_value_0)))
        else $error("result changed while stalled");

endmodule

bind uniform_grid_linear_resampler ugl_checker #(.VALUE_BITS(VALUE_BITS)) u_ugl_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .empty       (empty),
    .pop         (pop),
    .grid_time   (grid_time),
    .out_value_0 (out_value_0)
);

`default_nettype wire
